// File: src/mtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and constants for the modulation classifier
// Holds field widths, mode codes, fixed-point thresholds and the FSM type.
// ----------------------------------------------------------------------------
`default_nettype none
package mtc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;

    // thresholds rounded to the nearest step, halves away from zero
    localparam logic signed [33:0] Q_0_1    = 34'((ONE + 5) / 10);
    localparam logic signed [33:0] Q_0_3    = 34'((3 * ONE + 5) / 10);
    localparam logic signed [33:0] Q_0_15   = 34'((15 * ONE + 50) / 100);
    localparam logic signed [33:0] Q_0_25   = 34'((ONE + 2) / 4);
    localparam logic signed [33:0] Q_0_5    = 34'((ONE + 1) / 2);
    localparam logic signed [33:0] Q_0_05   = 34'((5 * ONE + 50) / 100);
    localparam logic signed [33:0] Q_0_8    = 34'((8 * ONE + 5) / 10);
    localparam logic signed [33:0] Q_0_6    = 34'((6 * ONE + 5) / 10);
    localparam logic signed [33:0] Q_0_2    = 34'((2 * ONE + 5) / 10);
    localparam logic signed [33:0] Q_0_4    = 34'((4 * ONE + 5) / 10);
    localparam logic signed [33:0] Q_M2     = 34'(-2 * ONE);
    localparam logic signed [33:0] Q_M1     = 34'(-ONE);
    localparam logic signed [33:0] Q_P2     = 34'(2 * ONE);
    localparam logic signed [33:0] Q_M1_5   = 34'(-((3 * ONE + 1) / 2));
    localparam logic signed [33:0] Q_M0_68  = 34'(-((68 * ONE + 50) / 100));
    localparam logic signed [33:0] Q_M0_62  = 34'(-((62 * ONE + 50) / 100));
    localparam logic signed [33:0] Q_M0_5   = 34'(-((ONE + 1) / 2));

    typedef enum logic [4:0] {
        MOD_NONE  = 5'd0,  MOD_CSS   = 5'd1,  MOD_OFDM  = 5'd2,  MOD_FHSS = 5'd3,
        MOD_DSSS  = 5'd4,  MOD_FMWB  = 5'd5,  MOD_FMNB  = 5'd6,  MOD_PM   = 5'd7,
        MOD_USB   = 5'd8,  MOD_LSB   = 5'd9,  MOD_DSBSC = 5'd10, MOD_CW   = 5'd11,
        MOD_DSBLC = 5'd12, MOD_GMSK  = 5'd13, MOD_FSK   = 5'd14, MOD_BPSK = 5'd15,
        MOD_QPSK  = 5'd16, MOD_8PSK  = 5'd17, MOD_PSK   = 5'd18, MOD_QAM16 = 5'd19,
        MOD_QAM64 = 5'd20, MOD_QAM32 = 5'd21
    } mod_code_t;

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_SNR_THRESH  = 2'd1,
        REG_FM_WIDEBAND = 2'd2,
        REG_ENV_LIMIT   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        LC_NONE = 2'd0,
        LC_NRZ  = 2'd1,
        LC_MANCHESTER = 2'd2
    } lcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_MULT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                classified;
        logic [4:0]          modulation_code;
        logic [6:0]          m_ary;
        logic signed [31:0]  ana_idx;
        logic [1:0]          lcode;
        logic [30:0]         symbol_rate_out;
        logic [30:0]         subcarrier_spacing_hz;
        logic [33:0]         bitrate;
        logic                is_tdma;
        logic                spread_flag;
        logic                is_ofdm;
    } result_t;

    typedef struct packed {
        logic [3:0]         feature_index;
        logic signed [31:0] feature_value;
        logic               last;
    } feature_t;

endpackage
`default_nettype wire

// File: src/mtc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_if: valid/ready channel
// Carries one payload item with a source and a sink view.
// ----------------------------------------------------------------------------
`default_nettype none
interface mtc_feature_if;
    import mtc_pkg::*;
    logic     valid;
    logic     ready;
    feature_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mtc_result_if;
    import mtc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/modulation_type_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulation_type_classifier_top: feature-set modulation classifier
// Stores feature words and walks a fixed-priority decision tree per set.
// ----------------------------------------------------------------------------
// Usage:
//   feat carries one feature word per item (index, value, last). Words not
//   marked last are stored at the accepting edge and ready stays high.
//   A word marked last is stored, then the block drops ready and enters the
//   decision state. Unclassified, chirp, spread, analog and OFDM sets with
//   no positive FFT size go from there straight to the output register.
//   Digital sets then pass a multiply state that forms the bit rate. OFDM
//   sets with a positive FFT size run a 31-step restoring divider, one
//   quotient bit a cycle. A stalled result holds the block, ready low, until
//   taken; ready returns the cycle after the result leaves. Words are taken
//   one per cycle while idle; a new set waits until the result has left.
//   Reset clears the store to zeros and the config registers to their
//   defaults. cfg_we/cfg_index/cfg_data write a register; the user must
//   write only when the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module modulation_type_classifier_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    mtc_feature_if.sink      feat,
    mtc_result_if.source     res
);
    import mtc_pkg::*;

    logic signed [31:0] store_reg [16];
    logic [30:0]        sample_rate_reg;
    logic signed [23:0] snr_thr_reg;
    logic [30:0]        fm_wb_reg;
    logic [16:0]        env_lim_reg;

    state_t  state_reg, state_next;
    result_t res_reg, res_next;
    logic [30:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] dvd_reg, dvd_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic accept;
    assign accept = feat.valid && feat.ready;
    assign feat.ready = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_OUT);
    assign res.data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                store_reg[i] <= '0;
            sample_rate_reg <= 31'd1000000;
            snr_thr_reg <= 24'sd327680;
            fm_wb_reg <= 31'd50000;
            env_lim_reg <= 17'd3277;
        end
        else
        begin
            if (accept)
                store_reg[feat.data.feature_index] <= feat.data.feature_value;
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                    REG_SNR_THRESH:  snr_thr_reg <= cfg_data[23:0];
                    REG_FM_WIDEBAND: fm_wb_reg <= cfg_data;
                    REG_ENV_LIMIT:   env_lim_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
    end

    // feature words, sign-extended to 34 bits for the compares; flags fl stay 32 bits
    logic signed [33:0] snr, env, fmd, bw, ph, fsd, fmn, ami, sym, flat, duty;
    logic signed [33:0] c40, c42, sr, fft;
    logic [31:0] fl;
    assign snr  = 34'(store_reg[0]);
    assign env  = 34'(store_reg[1]);
    assign fmd  = 34'(store_reg[2]);
    assign bw   = 34'(store_reg[3]);
    assign ph   = 34'(store_reg[4]);
    assign fsd  = 34'(store_reg[5]);
    assign fmn  = 34'(store_reg[6]);
    assign ami  = 34'(store_reg[7]);
    assign sym  = 34'(store_reg[8]);
    assign flat = 34'(store_reg[9]);
    assign duty = 34'(store_reg[10]);
    assign c40  = 34'(store_reg[11]);
    assign c42  = 34'(store_reg[12]);
    assign sr   = 34'(store_reg[13]);
    assign fft  = 34'(store_reg[14]);
    assign fl   = store_reg[15];

    // unsigned registers as positive signed values for signed compares
    logic signed [33:0] fm_wb_s, env_lim_s;
    assign fm_wb_s   = $signed({3'b0, fm_wb_reg});
    assign env_lim_s = $signed({17'b0, env_lim_reg});

    function automatic logic signed [33:0] abs34(input logic signed [33:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic logic near(input logic signed [33:0] x,
                                  input logic signed [33:0] c,
                                  input logic signed [33:0] m);
        return abs34(x - c) < m;
    endfunction

    // 38-bit products keep 10*bw and 18*sr exact
    logic signed [37:0] bw38, sr38, fmd38, fsd38;
    assign bw38  = 38'(bw);
    assign sr38  = 38'(sr);
    assign fmd38 = 38'(fmd);
    assign fsd38 = 38'(fsd);

    logic fm_like, pm_like, am_like;
    assign fm_like = (fmd38 * 38'sd10 > bw38) && (env < Q_0_1);
    assign pm_like = (ph > Q_0_3) && (env < Q_0_15) && (fsd38 * 38'sd10 < bw38);
    assign am_like = (env > Q_0_25) && (fmd38 * 38'sd4 < bw38);

    logic [1:0] log2m;
    logic [31:0] div_trial;
    assign div_trial = {rem_reg[30:0], dvd_reg[30]} - 32'(fft[30:0]);

    always_comb
    begin
        mod_code_t code;
        logic [6:0] m;
        state_next = state_reg;
        res_next = res_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        code = MOD_NONE;
        m = '0;
        log2m = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && feat.data.last)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                res_next = '0;
                res_next.classified = 1'b1;
                res_next.is_tdma = fl[0] && fl[5];
                res_next.spread_flag = fl[3] || fl[4];
                res_next.symbol_rate_out = sr > 0 ? sr[30:0] : '0;
                state_next = ST_OUT;
                if (snr < 34'(snr_thr_reg))
                    res_next.classified = 1'b0;
                else if (fl[1])
                begin
                    res_next.modulation_code = MOD_CSS;
                    res_next.m_ary = 7'd2;
                end
                else if (fl[2])
                begin
                    res_next.modulation_code = MOD_OFDM;
                    res_next.is_ofdm = 1'b1;
                    if (fft > 0)
                    begin
                        dvd_next = sample_rate_reg;
                        rem_next = '0;
                        quo_next = '0;
                        cnt_next = '0;
                        state_next = ST_DIVIDE;
                    end
                end
                else if (fl[3])
                    res_next.modulation_code = MOD_FHSS;
                else if (fl[4])
                    res_next.modulation_code = MOD_DSSS;
                else if (am_like || fm_like || pm_like)
                begin
                    if (fm_like)
                    begin
                        res_next.ana_idx = fmd[31:0];
                        res_next.modulation_code = (fmd > fm_wb_s) ? MOD_FMWB : MOD_FMNB;
                    end
                    else if (pm_like)
                    begin
                        res_next.ana_idx = ph[31:0];
                        res_next.modulation_code = MOD_PM;
                    end
                    else
                    begin
                        res_next.ana_idx = ami[31:0];
                        if (ami > Q_0_1 && sym < Q_0_5)
                            res_next.modulation_code = fmn > 0 ? MOD_USB : MOD_LSB;
                        else if (ami < Q_0_05 && env > Q_0_25)
                            res_next.modulation_code = MOD_DSBSC;
                        else if (flat > Q_0_8 || (fl[0] && duty < Q_0_6))
                        begin
                            res_next.ana_idx = '0;
                            res_next.modulation_code = MOD_CW;
                        end
                        else
                            res_next.modulation_code = MOD_DSBLC;
                    end
                end
                else
                begin
                    if (env < env_lim_s)
                    begin
                        if (flat < Q_0_2)
                        begin
                            code = MOD_GMSK;
                            m = 7'd2;
                        end
                        else if (near(c42, Q_M2, Q_0_5) && abs34(c40) < Q_0_3)
                        begin
                            code = MOD_FSK;
                            m = 7'd2;
                        end
                        else if (near(c40, Q_M2, Q_0_4) && c42 < Q_M1_5)
                        begin
                            code = MOD_BPSK;
                            m = 7'd2;
                        end
                        else if (near(c40, Q_M2, Q_0_5) && near(c42, Q_M1, Q_0_6))
                        begin
                            code = MOD_QPSK;
                            m = 7'd4;
                        end
                        else if (abs34(c40) < Q_0_4 && near(c42, Q_M1, Q_0_4))
                        begin
                            code = MOD_8PSK;
                            m = 7'd8;
                        end
                        else
                        begin
                            code = MOD_PSK;
                            m = 7'd2;
                        end
                    end
                    else
                    begin
                        if (near(c40, Q_M0_68, Q_0_2) && near(c42, Q_M0_68, Q_0_2))
                        begin
                            code = MOD_QAM16;
                            m = 7'd16;
                        end
                        else if (near(c40, Q_M0_62, Q_0_15) && near(c42, Q_M0_62, Q_0_15))
                        begin
                            code = MOD_QAM64;
                            m = 7'd64;
                        end
                        else if (near(c40, Q_M0_5, Q_0_2) && near(c42, Q_M0_5, Q_0_2))
                        begin
                            code = MOD_QAM32;
                            m = 7'd32;
                        end
                        else if (near(c40, Q_M2, Q_0_3) && near(c42, Q_P2, Q_0_3))
                        begin
                            code = MOD_BPSK;
                            m = 7'd2;
                        end
                        else if (near(c40, Q_M2, Q_0_4) && abs34(c42) < Q_0_2)
                        begin
                            code = MOD_QPSK;
                            m = 7'd4;
                        end
                        else
                        begin
                            code = MOD_QAM16;
                            m = 7'd16;
                        end
                    end
                    res_next.modulation_code = code;
                    res_next.m_ary = m;
                    if (code == MOD_GMSK || code == MOD_FSK)
                    begin
                        res_next.lcode = LC_NRZ;
                        if (bw > 0 && sr > 0 && bw38 * 38'sd10 > sr38 * 38'sd18
                            && bw38 * 38'sd2 < sr38 * 38'sd5)
                            res_next.lcode = LC_MANCHESTER;
                    end
                    state_next = ST_MULT;
                end
            end
            ST_DIVIDE:
            begin
                // restoring divide, one quotient bit a cycle
                dvd_next = {dvd_reg[29:0], 1'b0};
                if (!div_trial[31])
                begin
                    rem_next = div_trial;
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], dvd_reg[30]};
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    res_next.symbol_rate_out = quo_next;
                    res_next.subcarrier_spacing_hz = quo_next;
                    state_next = ST_OUT;
                end
            end
            ST_MULT:
            begin
                case (res_reg.m_ary)
                    7'd2:  log2m = 2'd1;
                    7'd4:  log2m = 2'd2;
                    7'd8:  log2m = 2'd3;
                    default: log2m = 2'd0;
                endcase
                // orders 16 to 64: log2 is 4 to 6, order 16 done with the shift form
                case (res_reg.m_ary)
                    7'd16: res_next.bitrate = {1'b0, res_reg.symbol_rate_out, 2'b0};
                    7'd32: res_next.bitrate = 34'(res_reg.symbol_rate_out) * 34'd5;
                    7'd64: res_next.bitrate = 34'(res_reg.symbol_rate_out) * 34'd6;
                    default: res_next.bitrate =
                        34'(res_reg.symbol_rate_out) * 34'(log2m);
                endcase
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: src/mtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_checker: port-level checks for the modulation classifier
// Watches the channels and flags protocol and result slips.
// ----------------------------------------------------------------------------
`default_nettype none
module mtc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        feat_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        res_classified,
    input wire logic [4:0]  res_code,
    input wire logic        res_ofdm
);
    import mtc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !feat_ready)
        else $error("input taken while result pending");

    a_uncl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_classified |-> res_code == MOD_NONE && !res_ofdm)
        else $error("unclassified result carries a mode");

    a_ofdm: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ofdm |-> res_code == MOD_OFDM)
        else $error("ofdm flag without ofdm code");

endmodule

bind modulation_type_classifier_top mtc_checker u_mtc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .feat_ready(feat.ready),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .res_classified(res.data.classified),
    .res_code(res.data.modulation_code),
    .res_ofdm(res.data.is_ofdm)
);
`default_nettype wire
